[sv/saph_pkg.sv]
// Package for the stepper axis position and homing controller.
// Holds the transaction payload types, the command, phase, notice and
// register codes, and the position width. No dependencies.
`default_nettype none

package saph_pkg;

  localparam int unsigned PosWidth   = 32;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [2:0] {
    CMD_POLL       = 3'd0,
    CMD_STEP_TICK  = 3'd1,
    CMD_HOME       = 3'd2,
    CMD_ZERO       = 3'd3,
    CMD_HALT       = 3'd4,
    CMD_SET_TARGET = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_RETURN = 2'd1,
    PH_SEEK   = 2'd2,
    PH_LEAVE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    NTC_NONE    = 2'd0,
    NTC_HOMED   = 2'd1,
    NTC_REACHED = 2'd2
  } notice_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_SWITCH_POLARITY  = 3'd0,
    CFG_INVERT_DIRECTION = 3'd1,
    CFG_LIMIT_ENABLE     = 3'd2,
    CFG_POSITION_MIN     = 3'd3,
    CFG_POSITION_MAX     = 3'd4,
    CFG_REFERENCE_OFFSET = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]                   command;
    logic signed [FieldWidth-1:0] target;
    logic                         reference_switch;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] position;
    logic                         moving;
    logic                         direction_pin;
    logic                         step_pulse;
    logic [1:0]                   homing_phase;
    logic                         rejected;
    logic [1:0]                   notice;
  } out_item_t;

endpackage

`default_nettype wire

[sv/stepper_axis_position_homing.sv]
// Stepper axis position controller with reference homing, one command per transaction.
// The result of an accepted transaction is registered in the result register.
// Throughput: one transaction per cycle; the result register and the axis state
// registers update together, so the input stalls only while a result waits unread.
// Reset clears axis state, valid flag, config flags and offset; sets widest limits.
// Depends on saph_pkg.
`default_nettype none

module stepper_axis_position_homing
  import saph_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_index_i,
  input  wire logic [FieldWidth-1:0]  cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_item_t               in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output out_item_t                   out_data_o
);

  typedef struct packed {
    logic running;
    logic heading_up;
  } motion_t;

  logic                         sw_pol_q;
  logic                         inv_dir_q;
  logic                         lim_en_q;
  logic signed [FieldWidth-1:0] pos_min_q;
  logic signed [FieldWidth-1:0] pos_max_q;
  logic signed [FieldWidth-1:0] ref_off_q;

  phase_e                       phase_q, phase_d;
  logic                         running_q, running_d;
  logic                         heading_q, heading_d;
  logic                         pend_move_q, pend_move_d;
  logic                         pend_home_q, pend_home_d;
  logic signed [PosWidth-1:0]   pos_q, pos_d;
  logic signed [PosWidth-1:0]   setp_q, setp_d;

  logic                         out_valid_q;
  out_item_t                    out_q, out_d;

  logic                         in_acc;
  logic                         active;
  logic                         pulse;
  logic                         rejected;
  notice_e                      notice;
  logic signed [PosWidth-1:0]   target_pos;
  logic signed [PosWidth-1:0]   offset_pos;
  motion_t                      mot;

  function automatic motion_t motion_request(motion_t cur, logic req_move, logic req_up);
    motion_t res;
    res = cur;
    if (!req_move) begin
      res.running = 1'b0;
    end else if (!cur.running) begin
      res.running    = 1'b1;
      res.heading_up = req_up;
    end
    return res;
  endfunction

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign active     = in_data_i.reference_switch != sw_pol_q;
  assign target_pos = PosWidth'(in_data_i.target);
  assign offset_pos = PosWidth'(ref_off_q);

  always_comb begin
    phase_d     = phase_q;
    running_d   = running_q;
    heading_d   = heading_q;
    pend_move_d = pend_move_q;
    pend_home_d = pend_home_q;
    pos_d       = pos_q;
    setp_d      = setp_q;
    pulse       = 1'b0;
    rejected    = 1'b0;
    notice      = NTC_NONE;
    mot         = '{running: running_q, heading_up: heading_q};
    unique case (cmd_e'(in_data_i.command))
      CMD_POLL: begin
        unique case (phase_q)
          PH_RETURN: begin
            mot = motion_request(mot, pos_q != setp_q, pos_q < setp_q);
            if (pos_q == setp_q) begin
              phase_d = PH_NORMAL;
            end
          end
          PH_SEEK: begin
            if (active) begin
              phase_d = PH_RETURN;
              pos_d   = offset_pos;
              setp_d  = '0;
            end else begin
              mot = motion_request(mot, 1'b1, 1'b0);
            end
          end
          PH_LEAVE: begin
            if (active) begin
              mot = motion_request(mot, 1'b1, 1'b1);
            end else begin
              mot     = motion_request(mot, 1'b0, 1'b0);
              phase_d = PH_SEEK;
            end
          end
          PH_NORMAL: begin
            mot = motion_request(mot, pos_q != setp_q, pos_q < setp_q);
          end
        endcase
        running_d = mot.running;
        heading_d = mot.heading_up;
        if (!mot.running && pend_move_q) begin
          if (pend_home_q && phase_d == PH_NORMAL) begin
            pend_move_d = 1'b0;
            pend_home_d = 1'b0;
            notice      = NTC_HOMED;
          end else if (!pend_home_q) begin
            pend_move_d = 1'b0;
            notice      = NTC_REACHED;
          end
        end
      end
      CMD_STEP_TICK: begin
        if (running_q && (phase_q == PH_SEEK || phase_q == PH_LEAVE || pos_q != setp_q)) begin
          pos_d = heading_q ? pos_q + PosWidth'(1) : pos_q - PosWidth'(1);
          pulse = 1'b1;
        end else begin
          running_d = 1'b0;
        end
      end
      CMD_HOME: begin
        pend_move_d = 1'b1;
        pend_home_d = 1'b1;
        phase_d     = active ? PH_LEAVE : PH_SEEK;
      end
      CMD_ZERO: begin
        pos_d  = '0;
        setp_d = '0;
      end
      CMD_HALT: begin
        phase_d = PH_NORMAL;
        setp_d  = pos_q;
      end
      CMD_SET_TARGET: begin
        if (lim_en_q && (in_data_i.target > pos_max_q || in_data_i.target < pos_min_q)) begin
          rejected = 1'b1;
        end else begin
          pend_move_d = 1'b1;
          setp_d      = target_pos;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_d.position      = FieldWidth'(pos_d);
    out_d.moving        = running_d;
    out_d.direction_pin = heading_d ^ inv_dir_q;
    out_d.step_pulse    = pulse;
    out_d.homing_phase  = phase_d;
    out_d.rejected      = rejected;
    out_d.notice        = notice;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_pol_q  <= 1'b0;
      inv_dir_q <= 1'b0;
      lim_en_q  <= 1'b0;
      pos_min_q <= {1'b1, {(FieldWidth-1){1'b0}}};
      pos_max_q <= {1'b0, {(FieldWidth-1){1'b1}}};
      ref_off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SWITCH_POLARITY:  sw_pol_q  <= cfg_wdata_i[0];
        CFG_INVERT_DIRECTION: inv_dir_q <= cfg_wdata_i[0];
        CFG_LIMIT_ENABLE:     lim_en_q  <= cfg_wdata_i[0];
        CFG_POSITION_MIN:     pos_min_q <= cfg_wdata_i;
        CFG_POSITION_MAX:     pos_max_q <= cfg_wdata_i;
        CFG_REFERENCE_OFFSET: ref_off_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NORMAL;
      running_q   <= 1'b0;
      heading_q   <= 1'b0;
      pend_move_q <= 1'b0;
      pend_home_q <= 1'b0;
      pos_q       <= '0;
      setp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q     <= phase_d;
        running_q   <= running_d;
        heading_q   <= heading_d;
        pend_move_q <= pend_move_d;
        pend_home_q <= pend_home_d;
        pos_q       <= pos_d;
        setp_q      <= setp_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("Input accepted while a result is stalled.");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("Accepted transaction produced no result.");

  a_step_while_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.step_pulse) |-> (out_q.moving && out_q.notice == NTC_NONE))
    else $error("Step pulse reported without motion.");

  a_homed_is_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.notice == NTC_HOMED) |->
      (!out_q.moving && out_q.homing_phase == PH_NORMAL))
    else $error("Homing notice while the axis is not at rest.");

  a_pending_home_implies_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_home_q |-> pend_move_q)
    else $error("Pending homing without a pending move.");
`endif

endmodule

`default_nettype wire
